### rtl/assert_macros.svh
// Assertion macros for the RTL files; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define IPK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge, reset included.
`define IPK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/ipk_pkg.sv
// Types and constants of the iambic mode B paddle keyer.
`default_nettype none

package ipk_pkg;

    localparam int DIT_W   = 16;
    localparam int WSD_W   = 4;
    localparam int POS_W   = 18;
    localparam int GAP_W   = 20;
    localparam int CFG_W   = 16;

    localparam logic [DIT_W-1:0] DIT_SAMPLES_RST = 16'd2880;
    localparam logic [WSD_W-1:0] WORD_SPACE_RST  = 4'd7;
    localparam logic [GAP_W-1:0] GAP_MAX         = 20'hFFFFF;

    typedef enum logic [0:0] {
        CFG_DIT_SAMPLES = 1'b0,
        CFG_WORD_SPACE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ELEM_NONE = 2'd0,
        ELEM_DIT  = 2'd1,
        ELEM_DAH  = 2'd2
    } t_elem;

    typedef struct packed {
        t_elem             active_element;
        logic [POS_W-1:0]  envelope_index;
        t_elem             element_symbol;
        logic              char_end;
        logic              word_space;
    } t_result;

endpackage

`default_nettype wire

### rtl/ipk_cfg.sv
// Configuration registers: dit length and word space threshold.
`default_nettype none

module ipk_cfg
    import ipk_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [0:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    output logic      [DIT_W-1:0] o_dit_samples,
    output logic      [WSD_W-1:0] o_space_dits
);

    logic [DIT_W-1:0] r_dit_samples;
    logic [WSD_W-1:0] r_space_dits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit_samples <= DIT_SAMPLES_RST;
            r_space_dits  <= WORD_SPACE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DIT_SAMPLES: r_dit_samples <= i_cfg_wdata[DIT_W-1:0];
                CFG_WORD_SPACE:  r_space_dits  <= i_cfg_wdata[WSD_W-1:0];
            endcase
        end
    end

    assign o_dit_samples = r_dit_samples;
    assign o_space_dits  = r_space_dits;

endmodule

`default_nettype wire

### rtl/ipk_core.sv
// Keyer state and the per-tick next-state and result logic.
`default_nettype none

module ipk_core
    import ipk_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic             i_dit,
    input  wire logic             i_dah,
    input  wire logic [DIT_W-1:0] i_dit_samples,
    input  wire logic [WSD_W-1:0] i_space_dits,
    output t_result               o_res
);

    logic             r_prev_dit, r_prev_dah;
    logic             r_dit_mem, r_dah_mem;
    t_elem            r_cur;
    logic [POS_W-1:0] r_pos;
    logic [GAP_W-1:0] r_gap;
    logic             r_space_done;
    logic             r_ever_ended;

    logic             n_dit_mem, n_dah_mem;
    t_elem            n_cur;
    logic [POS_W-1:0] n_pos;
    logic [GAP_W-1:0] n_gap;
    logic             n_space_done;
    logic             n_ever_ended;

    // shared per-tick terms
    logic             idle;
    logic [GAP_W-1:0] thresh;
    logic             ws_hit;
    logic             mem_dit, mem_dah;
    t_elem            snd;
    logic             sounding;
    logic [POS_W-1:0] pos_base, pos_inc;
    logic [POS_W-1:0] elem_len;
    logic [GAP_W-1:0] gap_a, gap_sat;
    logic             ends;
    logic             space_a;
    logic             own_mem, opp_mem;
    logic             end_dit_mem, end_dah_mem;

    always_comb begin
        idle    = (r_cur == ELEM_NONE);
        thresh  = GAP_W'(i_space_dits) * GAP_W'(i_dit_samples);
        ws_hit  = idle && r_ever_ended && !r_space_done && (r_gap > thresh);
        gap_a   = ws_hit ? '0 : r_gap;
        gap_sat = (gap_a == GAP_MAX) ? gap_a : gap_a + 1'b1;

        mem_dit = r_dit_mem | (i_dit & ~r_prev_dit);
        mem_dah = r_dah_mem | (i_dah & ~r_prev_dah);
        if (idle) begin
            mem_dit = mem_dit & i_dit;
            mem_dah = mem_dah & i_dah;
        end

        if (!idle) begin
            snd = r_cur;
        end else if (mem_dit) begin
            snd = ELEM_DIT;
        end else if (mem_dah) begin
            snd = ELEM_DAH;
        end else begin
            snd = ELEM_NONE;
        end
        sounding = (snd != ELEM_NONE);
        space_a  = idle ? ((r_space_done | ws_hit) & ~sounding) : r_space_done;

        pos_base = idle ? '0 : r_pos;
        pos_inc  = pos_base + 1'b1;
        elem_len = (snd == ELEM_DIT) ? {1'b0, i_dit_samples, 1'b0} : {i_dit_samples, 2'b00};
        ends     = sounding && (pos_inc >= elem_len);

        end_dit_mem = (snd == ELEM_DIT) ? (mem_dit & i_dit) : mem_dit;
        end_dah_mem = (snd == ELEM_DAH) ? (mem_dah & i_dah) : mem_dah;
        own_mem     = (snd == ELEM_DIT) ? end_dit_mem : end_dah_mem;
        opp_mem     = (snd == ELEM_DIT) ? end_dah_mem : end_dit_mem;
    end

    // next state
    always_comb begin
        n_dit_mem    = mem_dit;
        n_dah_mem    = mem_dah;
        n_cur        = snd;
        n_pos        = '0;
        n_gap        = gap_sat;
        n_space_done = space_a;
        n_ever_ended = r_ever_ended;
        if (ends) begin
            n_dit_mem    = end_dit_mem;
            n_dah_mem    = end_dah_mem;
            n_gap        = '0;
            n_ever_ended = 1'b1;
            if (opp_mem) begin
                n_cur = (snd == ELEM_DIT) ? ELEM_DAH : ELEM_DIT;
            end else if (own_mem) begin
                n_cur = snd;
            end else begin
                n_cur        = ELEM_NONE;
                n_space_done = 1'b0;
            end
        end else if (sounding) begin
            n_pos = pos_inc;
        end
    end

    // result
    always_comb begin
        o_res.active_element = snd;
        o_res.envelope_index = pos_base;
        o_res.element_symbol = ends ? snd : ELEM_NONE;
        o_res.char_end       = ends && !opp_mem && !own_mem;
        o_res.word_space     = ws_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_dit   <= 1'b0;
            r_prev_dah   <= 1'b0;
            r_dit_mem    <= 1'b0;
            r_dah_mem    <= 1'b0;
            r_cur        <= ELEM_NONE;
            r_pos        <= '0;
            r_gap        <= '0;
            r_space_done <= 1'b0;
            r_ever_ended <= 1'b0;
        end else if (i_step) begin
            r_prev_dit   <= i_dit;
            r_prev_dah   <= i_dah;
            r_dit_mem    <= n_dit_mem;
            r_dah_mem    <= n_dah_mem;
            r_cur        <= n_cur;
            r_pos        <= n_pos;
            r_gap        <= n_gap;
            r_space_done <= n_space_done;
            r_ever_ended <= n_ever_ended;
        end
    end

endmodule

`default_nettype wire

### rtl/iambic_b_paddle_keyer.sv
// Top level of the iambic mode B paddle keyer.
//
//  channel   direction  handshake           payload
//  paddles   in         i_valid / o_stall   i_dit_pressed, i_dah_pressed
//  result    out        o_valid / i_stall   o_active_element .. o_word_space
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_wdata
//
// One beat per cycle sustained while i_stall is low; each beat passes through the
// input register and then the result register before its result is valid. Keyer state
// advances when the input register hands its beat to the result register. A stalled
// result holds the input register; o_stall rises only while both registers are full.
// Synchronous active-low reset clears control state and loads register defaults.
`default_nettype none
`include "assert_macros.svh"

module iambic_b_paddle_keyer
    import ipk_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_dit_pressed,
    input  wire logic             i_dah_pressed,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic      [1:0]       o_active_element,
    output logic      [POS_W-1:0] o_envelope_index,
    output logic      [1:0]       o_element_symbol,
    output logic                  o_char_end,
    output logic                  o_word_space,
    input  wire logic             i_cfg_we,
    input  wire logic [0:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    logic             r_in_vld;
    logic             r_in_dit, r_in_dah;
    logic             r_out_vld;
    t_result          r_res;
    logic             step;
    logic             in_take;
    logic [DIT_W-1:0] dit_samples;
    logic [WSD_W-1:0] space_dits;
    t_result          res;

    assign step    = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && r_out_vld && i_stall;
    assign in_take = i_valid && !o_stall;

    ipk_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_dit_samples (dit_samples),
        .o_space_dits  (space_dits)
    );

    ipk_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_dit         (r_in_dit),
        .i_dah         (r_in_dah),
        .i_dit_samples (dit_samples),
        .i_space_dits  (space_dits),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (step) begin
                r_in_vld <= 1'b0;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_dit <= i_dit_pressed;
            r_in_dah <= i_dah_pressed;
        end
        if (step) begin
            r_res <= res;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_active_element = r_res.active_element;
    assign o_envelope_index = r_res.envelope_index;
    assign o_element_symbol = r_res.element_symbol;
    assign o_char_end       = r_res.char_end;
    assign o_word_space     = r_res.word_space;

    `IPK_ASSERT(a_cend_has_symbol,
        (o_valid && o_char_end) |-> (o_element_symbol != ELEM_NONE),
        "char end without element symbol")
    `IPK_ASSERT(a_space_at_start, (o_valid && o_word_space) |-> (o_envelope_index == '0),
        "word space inside an element")
    `IPK_ASSERT(a_env_needs_elem,
        (o_valid && (o_envelope_index != '0)) |-> (o_active_element != ELEM_NONE),
        "envelope position while idle")
    `IPK_ASSERT_ALWAYS(a_stall_only_full, o_stall |-> (r_in_vld && r_out_vld && i_stall),
        "stall without both registers full")

endmodule

`default_nettype wire
